@@ rtl/core/owse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package owse_pkg;

  // Fixed field and register widths
  localparam int WORD_W     = 40;
  localparam int WORD_IDX_W = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int TDATA_W    = 8;
  localparam int NUM_SLOTS  = 8;

  // Parameter defaults
  localparam int SAMPLE_COUNT_DEF = 8;
  localparam int FRAME_BITS_DEF   = 40;

  // Read counts of the pin waveform
  localparam int RESP_READS   = 16;
  localparam int RESP_LOW     = 8;
  localparam int BIT_LOW      = 5;
  localparam int BIT0_READS   = 7;
  localparam int BIT1_READS   = 12;
  localparam int FINISH_READS = 4;

  // Sensor phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_RESP   = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_FINISH = 2'd3;

  // Power-up frames of the sample slots, byte 0 in the top bits
  localparam logic [WORD_W-1:0] WORD_RESET [NUM_SLOTS] = '{
    40'h320018004A, 40'h2300140037, 40'h3700120049, 40'h2D000A0037,
    40'h14000D0021, 40'h4100110052, 40'h5000150065, 40'h28001C0044
  };

  // Index width for n entries, at least one bit
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // One accepted pin access
  typedef struct packed {
    logic fire;
    logic is_read;
    logic write_level;
  } access_t;

  // Result of one access
  typedef struct packed {
    logic pin_level;
    logic read_valid;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/owse_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module owse_seq #(
  parameter int SAMPLE_COUNT = owse_pkg::SAMPLE_COUNT_DEF,
  parameter int FRAME_BITS   = owse_pkg::FRAME_BITS_DEF
) (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  owse_pkg::access_t                            acc,
  input  wire                                          data_bit,
  output owse_pkg::result_t                            res,
  output logic [owse_pkg::idx_w(SAMPLE_COUNT)-1:0]     sample_idx,
  output logic [owse_pkg::WORD_IDX_W-1:0]              bit_pos
);
  import owse_pkg::*;

  localparam int SIDX_W = idx_w(SAMPLE_COUNT);
  localparam int BIT_W  = idx_w(FRAME_BITS);

  logic [1:0]        phase_r, phase_nxt;
  logic [3:0]        tick_r, tick_nxt;
  logic [BIT_W-1:0]  bit_idx_r, bit_idx_nxt;
  logic [SIDX_W-1:0] sidx_r, sidx_nxt;
  logic [3:0]        bit_len;
  logic              level;

  assign sample_idx = sidx_r;
  assign bit_pos    = WORD_IDX_W'(FRAME_BITS - 1) - WORD_IDX_W'(bit_idx_r);
  assign bit_len    = data_bit ? 4'(BIT1_READS) : 4'(BIT0_READS);

  // Next state and pin level for one access
  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    bit_idx_nxt = bit_idx_r;
    sidx_nxt    = sidx_r;
    level       = 1'b1;
    if (acc.is_read) begin
      case (phase_r)
        PH_RESP: begin
          level = (tick_r >= 4'(RESP_LOW));
          if (tick_r == 4'(RESP_READS - 1)) begin
            tick_nxt  = '0;
            phase_nxt = PH_DATA;
            sidx_nxt  = (sidx_r == SIDX_W'(SAMPLE_COUNT - 1)) ? '0 : sidx_r + 1'b1;
          end else begin
            tick_nxt = tick_r + 1'b1;
          end
        end
        PH_DATA: begin
          level = (tick_r >= 4'(BIT_LOW));
          if (tick_r >= bit_len - 1'b1) begin
            tick_nxt = '0;
            if (bit_idx_r == BIT_W'(FRAME_BITS - 1)) begin
              bit_idx_nxt = '0;
              phase_nxt   = PH_FINISH;
            end else begin
              bit_idx_nxt = bit_idx_r + 1'b1;
            end
          end else begin
            tick_nxt = tick_r + 1'b1;
          end
        end
        PH_FINISH: begin
          if (tick_r < 4'(FINISH_READS - 1)) begin
            level    = 1'b0;
            tick_nxt = tick_r + 1'b1;
          end else begin
            tick_nxt  = '0;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          level = 1'b1;
        end
      endcase
    end else begin
      // host drive: only a high level in idle starts a transfer
      level = 1'b0;
      if (phase_r == PH_IDLE && acc.write_level) begin
        phase_nxt = PH_RESP;
      end
    end
  end

  assign res.pin_level  = level;
  assign res.read_valid = acc.is_read;

  // State registers, updated on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      bit_idx_r <= '0;
      sidx_r    <= '0;
    end else if (acc.fire) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bit_idx_r <= bit_idx_nxt;
      sidx_r    <= sidx_nxt;
    end
  end

  // Counters stay inside the frame and slot ranges
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_idx_r <= BIT_W'(FRAME_BITS - 1))
    else $error("bit index past frame");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    sidx_r <= SIDX_W'(SAMPLE_COUNT - 1))
    else $error("sample index past slot count");

  // Idle leaves no partial count behind
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> (tick_r == '0 && bit_idx_r == '0))
    else $error("idle with live counters");

  // A data bit never runs past the long bit length
  a_tick_data: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> tick_r < 4'(BIT1_READS))
    else $error("data tick overrun");

endmodule

`default_nettype wire

@@ rtl/core/one_wire_sensor_emulator.sv @@
// Channel | Dir | Handshake            | Payload
// in_     | in  | in_tvalid/in_tready  | tdata: write_level; tuser: action (1 = read)
// out_    | out | out_tvalid/out_tready| tdata: pin_level; tuser: read_valid
// cfg_    | in  | cfg_valid/cfg_ready  | cfg_index: slot, cfg_data: 40-bit frame
//
// One pin access per clock unless stalled; each accepted word gives one result in
// the next cycle from the output register. The sensor state updates at accept, so
// a new word can follow every cycle while the previous result is still held.
// Input is stalled only while a result waits and out_tready is low.
// rst_n is synchronous, active low; it restores idle and the default frames.
// Configuration is always ready; writes to slots at or past SAMPLE_COUNT are dropped.
`timescale 1ns / 1ps
`default_nettype none

module one_wire_sensor_emulator #(
  parameter int SAMPLE_COUNT = owse_pkg::SAMPLE_COUNT_DEF,
  parameter int FRAME_BITS   = owse_pkg::FRAME_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [owse_pkg::TDATA_W-1:0]         in_tdata,   // [0] write_level
  input  wire                                  in_tuser,   // [0] action
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [owse_pkg::TDATA_W-1:0]         out_tdata,  // [0] pin_level
  output logic                                 out_tuser,  // [0] read_valid
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [owse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [owse_pkg::WORD_W-1:0]          cfg_data
);
  import owse_pkg::*;

  localparam int SIDX_W = idx_w(SAMPLE_COUNT);

  logic [WORD_W-1:0]  word_r [SAMPLE_COUNT];
  logic               out_tvalid_r;
  logic [TDATA_W-1:0] out_tdata_r;
  logic               out_tuser_r;
  logic               in_fire;
  logic               cfg_hit;
  access_t            acc;
  result_t            res;
  logic [SIDX_W-1:0]  sample_idx;
  logic [WORD_IDX_W-1:0] bit_pos;
  logic               data_bit;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && ({1'b0, cfg_index} < (CFG_IDX_W + 1)'(SAMPLE_COUNT));

  assign acc.fire        = in_fire;
  assign acc.is_read     = in_tuser;
  assign acc.write_level = in_tdata[0];

  // Bit of the current slot's frame being sent
  assign data_bit = word_r[sample_idx][bit_pos];

  owse_seq #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .FRAME_BITS   (FRAME_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .data_bit   (data_bit),
    .res        (res),
    .sample_idx (sample_idx),
    .bit_pos    (bit_pos)
  );

  // Sample frame registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
        word_r[i] <= WORD_RESET[i];
      end
    end else if (cfg_hit) begin
      word_r[cfg_index[SIDX_W-1:0]] <= cfg_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= {{(TDATA_W - 1){1'b0}}, res.pin_level};
      out_tuser_r <= res.read_valid;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // A write access always reports a low pin
  a_write_low: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_tuser |=> out_tdata_r[0] == 1'b0 && !out_tuser_r)
    else $error("write access returned high pin");

  // Each accepted word loads a result
  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid_r)
    else $error("accepted word produced no result");

  // Padding bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> out_tdata_r[TDATA_W-1:1] == '0)
    else $error("result padding not zero");

endmodule

`default_nettype wire

@@ bench/owse_pin_checker.sv @@
`timescale 1ns / 1ps

// Watches the access, result and frame-write channels of the sensor emulator,
// predicts the pin answer of every accepted access word and compares it with
// the result words in order.
module owse_pin_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [owse_pkg::TDATA_W-1:0]  in_tdata,   // [0] write_level
  input  logic                          in_tuser,   // [0] action
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [owse_pkg::TDATA_W-1:0]  out_tdata,  // [0] pin_level
  input  logic                          out_tuser,  // [0] read_valid
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [owse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owse_pkg::WORD_W-1:0]   cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import owse_pkg::*;

  localparam int FRAME_LEN  = FRAME_BITS_DEF;
  localparam int SLOTS_USED = SAMPLE_COUNT_DEF;

  // Shadow copy of the sensor: frames and waveform position
  logic [WORD_W-1:0] frame_words [NUM_SLOTS];
  logic [1:0]        sensor_phase = PH_IDLE;
  logic [3:0]        read_ticks   = '0;
  logic [5:0]        bit_pos      = '0;
  logic [2:0]        slot         = '0;
  result_t           expected_answers [$];
  int                errors       = 0;

  initial begin
    fail_count  = 0;
    pending     = 0;
    for (int i = 0; i < NUM_SLOTS; i++) frame_words[i] = WORD_RESET[i];
  end

  // Pin level the sensor answers to one read; advances the waveform
  function automatic logic predict_pin_read();
    int   nxt;
    int   len;
    logic lvl;
    logic data_bit;
    lvl = 1'b1;
    case (sensor_phase)
      PH_RESP: begin
        nxt = int'(read_ticks) + 1;
        lvl = (nxt > RESP_LOW);
        if (nxt >= RESP_READS) begin
          read_ticks   = '0;
          sensor_phase = PH_DATA;
          // slot moves on before the data bits use it
          if (int'(slot) + 1 >= SLOTS_USED) slot = '0;
          else slot = slot + 3'd1;
        end else begin
          read_ticks = 4'(nxt);
        end
      end
      PH_DATA: begin
        if (int'(slot) < SLOTS_USED && int'(bit_pos) < FRAME_LEN)
          data_bit = frame_words[slot][FRAME_LEN - 1 - int'(bit_pos)];
        else
          data_bit = 1'b0;
        len = data_bit ? BIT1_READS : BIT0_READS;
        lvl = (int'(read_ticks) >= BIT_LOW);
        nxt = int'(read_ticks) + 1;
        if (nxt >= len) begin
          read_ticks = '0;
          bit_pos    = bit_pos + 6'd1;
          if (int'(bit_pos) >= FRAME_LEN) begin
            bit_pos      = '0;
            sensor_phase = PH_FINISH;
          end
        end else begin
          read_ticks = 4'(nxt);
        end
      end
      PH_FINISH: begin
        nxt = int'(read_ticks) + 1;
        if (nxt < FINISH_READS) begin
          lvl        = 1'b0;
          read_ticks = 4'(nxt);
        end else begin
          read_ticks   = '0;
          sensor_phase = PH_IDLE;
        end
      end
      default: ;  // idle reads answer high
    endcase
    return lvl;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) frame_words[i] = WORD_RESET[i];
      sensor_phase = PH_IDLE;
      read_ticks   = '0;
      bit_pos      = '0;
      slot         = '0;
      expected_answers.delete();
    end else begin
      // result word: compare with the oldest prediction first
      if (out_tvalid && out_tready) begin
        if (expected_answers.size() == 0) begin
          $error("result word with no access pending: pin_level %0d read_valid %0d",
                 out_tdata[0], out_tuser);
          errors++;
        end else begin
          want = expected_answers.pop_front();
          if (out_tdata[0] !== want.pin_level) begin
            $error("pin_level mismatch: expected %0d, actual %0d",
                   want.pin_level, out_tdata[0]);
            errors++;
          end
          if (out_tuser !== want.read_valid) begin
            $error("read_valid mismatch: expected %0d, actual %0d",
                   want.read_valid, out_tuser);
            errors++;
          end
        end
      end
      // frame write
      if (cfg_valid && cfg_ready) begin
        if (int'(cfg_index) < NUM_SLOTS) frame_words[cfg_index] = cfg_data;
      end
      // access word
      if (in_tvalid && in_tready) begin
        if (in_tuser) begin
          fresh.pin_level  = predict_pin_read();
          fresh.read_valid = 1'b1;
        end else begin
          if (sensor_phase == PH_IDLE && in_tdata[0]) sensor_phase = PH_RESP;
          fresh = '0;
        end
        expected_answers.push_back(fresh);
      end
    end
    fail_count  <= errors;
    pending     <= expected_answers.size();
  end

endmodule

@@ bench/tb_one_wire_sensor_emulator.sv @@
`timescale 1ns / 1ps

module tb_one_wire_sensor_emulator;
  import owse_pkg::*;

  localparam int PHASE_ITEMS  = 125;
  localparam int HOLD_START   = 400;   // receiver stall window, in cycles
  localparam int HOLD_LEN     = 90;
  localparam int CALM_START   = 900;   // receiver never stalls here
  localparam int CALM_END     = 1400;
  localparam int STEADY_FIRST = 250;   // sender adds no random gap after these words
  localparam int STEADY_LAST  = 400;
  localparam int STALL_LIMIT  = 2000;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [TDATA_W-1:0]      in_tdata   = '0;   // [0] write_level
  logic                    in_tuser   = 1'b0; // [0] action
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [TDATA_W-1:0]      out_tdata;         // [0] pin_level
  logic                    out_tuser;         // [0] read_valid
  logic                    cfg_valid  = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [WORD_W-1:0]       cfg_data   = '0;

  int   fail_count;
  int   pending;
  int   words_sent = 0;
  int   quiet_cycles = 0;

  one_wire_sensor_emulator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  owse_pin_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, one long hold-off, one stretch without stalls
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
        out_tready <= 1'b0;
      else if (cyc >= CALM_START && cyc < CALM_END)
        out_tready <= 1'b1;
      else
        out_tready <= ($urandom_range(99, 0) >= 27);
    end
  end

  // Watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // One access word; may leave a random gap after it is taken
  task automatic send_access(input logic is_read, input logic level);
    in_tvalid <= 1'b1;
    in_tuser  <= is_read;
    in_tdata  <= {{(TDATA_W - 1){1'b0}}, level};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (!(words_sent >= STEADY_FIRST && words_sent < STEADY_LAST) &&
        $urandom_range(99, 0) < 19) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Mostly reads, some writes of either level; writes of 1 in idle start transfers
  task automatic random_accesses(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99, 0) < 85)
        send_access(1'b1, 1'($urandom_range(1, 0)));
      else
        send_access(1'b0, 1'($urandom_range(1, 0)));
    end
  endtask

  // Stop sending and let all results drain
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_frame(input int idx, input logic [WORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  initial begin
    logic [WORD_W-1:0] frame;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle answers, ignored writes, start, full response, data start
    send_access(1'b1, 1'b0);   // idle read answers high
    send_access(1'b0, 1'b0);   // write of 0 in idle is ignored
    send_access(1'b1, 1'b1);
    send_access(1'b0, 1'b1);   // start
    send_access(1'b0, 1'b1);   // writes outside idle are ignored
    send_access(1'b0, 1'b0);
    for (int i = 0; i < RESP_READS; i++) send_access(1'b1, 1'(i & 1));
    send_access(1'b0, 1'b1);   // ignored during data
    send_access(1'b1, 1'b1);
    send_access(1'b1, 1'b0);

    // Power-up frames
    random_accesses(PHASE_ITEMS);
    drain_results();

    // Reprogram every slot once drained: zeros, ones, random, stripes, random
    for (int ph = 1; ph <= 5; ph++) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        case (ph)
          1:       frame = '0;
          2:       frame = '1;
          4:       frame = s[0] ? 40'h5555555555 : 40'hAAAAAAAAAA;
          default: frame = WORD_W'({$urandom, $urandom});
        endcase
        write_frame(s, frame);
      end
      cfg_valid <= 1'b0;
      send_access(1'b0, 1'b1);
      random_accesses(PHASE_ITEMS);
      drain_results();
    end

    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
